// ===== hdl/cslbp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the center-symmetric LBP 3x3 block.
// No dependencies; imported by every module under hdl/.
package cslbp_pkg;

    localparam int PIX_W      = 8;
    localparam int CODE_W     = 5;
    localparam int ROW_W      = 12;
    localparam int COL_OUT_W  = 10;
    localparam int IMG_W_W    = 11;
    localparam int THR_W      = 9;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int MIN_DIM    = 3;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH    = 2'd0,
        CFG_IMAGE_HEIGHT   = 2'd1,
        CFG_DIFF_THRESHOLD = 2'd2
    } cfg_index_t;

    typedef logic [PIX_W-1:0] pix_t;

    // One line store entry: pixel of the row above and of the row before that
    typedef struct packed {
        pix_t recent;
        pix_t older;
    } line_pair_t;

    // 3x3 window, index 0 is top-left, 8 is bottom-right
    typedef pix_t [8:0] window_t;

    typedef struct packed {
        logic [CODE_W-1:0]    code;
        logic [ROW_W-1:0]     row;
        logic [COL_OUT_W-1:0] col;
        logic                 last;
    } result_t;

endpackage

// ===== hdl/cslbp_line_store.sv =====
`timescale 1ns / 1ps
// Two stacked line stores in one synchronous RAM with a registered read.
// Forwards the write of the same cycle when it hits the entry being read. Uses cslbp_pkg.
module cslbp_line_store
    import cslbp_pkg::*;
#(
    parameter int DEPTH = 1024,
    localparam int IDX_W = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_idx,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  line_pair_t       wr_data,
    output line_pair_t       rd_data
);

    line_pair_t line_mem [DEPTH];
    line_pair_t rdata_reg;
    line_pair_t fwd_data_reg;
    logic       fwd_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[wr_idx] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg    <= line_mem[rd_idx];
            fwd_data_reg <= wr_data;
        end
    end

    // RAM returns the old entry on a same-address collision; take the new one instead
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg <= 1'b0;
        end else if (rd_en) begin
            fwd_reg <= wr_en && (wr_idx == rd_idx);
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : rdata_reg;

endmodule

// ===== hdl/cslbp_code_unit.sv =====
`timescale 1ns / 1ps
// Pattern logic: four opposite-pair threshold tests and center-vs-mean test.
// Purely combinational over one 3x3 window. Uses cslbp_pkg.
module cslbp_code_unit
    import cslbp_pkg::*;
(
    input  window_t                  win,
    input  logic signed [THR_W-1:0]  threshold,
    output logic        [CODE_W-1:0] code
);

    function automatic logic pair_above(input pix_t a, input pix_t b,
                                        input logic signed [THR_W-1:0] t);
        logic signed [PIX_W+1:0] diff;
        logic signed [PIX_W+1:0] t_ext;
        diff  = $signed({2'b00, a}) - $signed({2'b00, b});
        t_ext = {t[THR_W-1], t};
        return diff > t_ext;
    endfunction

    logic [PIX_W+2:0] nb_sum;
    pix_t             nb_mean;

    always_comb begin
        nb_sum = (PIX_W+3)'(win[0]) + (PIX_W+3)'(win[1]) + (PIX_W+3)'(win[2])
               + (PIX_W+3)'(win[3]) + (PIX_W+3)'(win[5]) + (PIX_W+3)'(win[6])
               + (PIX_W+3)'(win[7]) + (PIX_W+3)'(win[8]);
        nb_mean = nb_sum[PIX_W+2:3];
        code[0] = pair_above(win[1], win[7], threshold);
        code[1] = pair_above(win[2], win[6], threshold);
        code[2] = pair_above(win[5], win[3], threshold);
        code[3] = pair_above(win[8], win[0], threshold);
        code[4] = win[4] > nb_mean;
    end

endmodule

// ===== hdl/center_symmetric_lbp_3x3.sv =====
`timescale 1ns / 1ps
// Center-symmetric LBP 3x3 top level: counters, line store, window, output queue.
// Depends on cslbp_pkg, cslbp_line_store and cslbp_code_unit.
//
// Takes one 8-bit pixel per clock in raster order and emits a 5-bit code for every
// interior center pixel, one pixel per cycle sustained with no bubbles while m_ready
// stays high. An accepted pixel reads its column of the line-store RAM in the accept
// cycle, writes it back and shifts the window in the next, and its code is computed
// from the registered window and pushed into a four-entry output queue.
// The input stalls only when the queue plus results in flight reach four.
// There is no clearing pass after reset; line store entries are undefined until
// written, which the first two rows of a frame do before any code reads them.
module center_symmetric_lbp_3x3
    import cslbp_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [PIX_W-1:0]      s_pixel,
    input  logic                  s_first,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CODE_W-1:0]     m_code,
    output logic [ROW_W-1:0]      m_center_row,
    output logic [COL_OUT_W-1:0]  m_center_col,
    output logic                  m_last
);

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int EW      = COL_W + 1;
    localparam int CMP_W   = (EW > IMG_W_W) ? EW : IMG_W_W;
    localparam int COL_X_W = (COL_W > COL_OUT_W) ? COL_W : COL_OUT_W;

    // configuration
    logic [IMG_W_W-1:0]      image_width_reg;
    logic [ROW_W-1:0]        image_height_reg;
    logic signed [THR_W-1:0] diff_threshold_reg;
    logic [CMP_W-1:0]        width_ext;
    logic [CMP_W-1:0]        width_clamped;
    logic [EW-1:0]           eff_width;
    logic [ROW_W-1:0]        eff_height;

    // position counters
    logic [ROW_W-1:0] row_count_reg, row_count_next;
    logic [COL_W-1:0] col_count_reg, col_count_next;
    logic [ROW_W-1:0] row_cur;
    logic [COL_W-1:0] col_cur;
    logic [EW-1:0]    col_cur_ext;
    logic [EW-1:0]    col_inc;
    logic [ROW_W:0]   row_inc;
    logic             emit_now;
    logic             last_now;
    logic [COL_X_W-1:0] center_col_ext;
    logic             in_xfer;

    // stage 1: line store data arrives
    logic                 s1_valid_reg;
    logic                 s1_emit_reg;
    logic                 s1_last_reg;
    pix_t                 s1_pixel_reg;
    logic [COL_W-1:0]     s1_idx_reg;
    logic [ROW_W-1:0]     s1_row_reg;
    logic [COL_OUT_W-1:0] s1_col_reg;
    line_pair_t           lines_rd;
    line_pair_t           lines_wr;
    window_t              window_reg, window_next;

    // stage 2: code computation
    logic                 s2_valid_reg;
    logic                 s2_last_reg;
    logic [ROW_W-1:0]     s2_row_reg;
    logic [COL_OUT_W-1:0] s2_col_reg;
    logic [CODE_W-1:0]    s2_code;

    // output queue
    result_t               fifo_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] fifo_wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] fifo_rd_ptr_reg;
    logic [FIFO_PTR_W:0]   fifo_cnt_reg, fifo_cnt_next;
    logic                  fifo_push;
    logic                  fifo_pop;
    logic [FIFO_PTR_W:0]   pending;
    result_t               head;

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg    <= IMG_W_W'(640);
            image_height_reg   <= ROW_W'(480);
            diff_threshold_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:    image_width_reg    <= cfg_wdata[IMG_W_W-1:0];
                CFG_IMAGE_HEIGHT:   image_height_reg   <= cfg_wdata[ROW_W-1:0];
                CFG_DIFF_THRESHOLD: diff_threshold_reg <= $signed(cfg_wdata[THR_W-1:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        width_ext = CMP_W'(image_width_reg);
        if (width_ext < CMP_W'(MIN_DIM)) begin
            width_clamped = CMP_W'(MIN_DIM);
        end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
            width_clamped = CMP_W'(MAX_WIDTH);
        end else begin
            width_clamped = width_ext;
        end
        eff_width  = width_clamped[EW-1:0];
        eff_height = (image_height_reg < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) : image_height_reg;
    end

    // ---------------- counters and emit decision ----------------
    assign in_xfer = s_valid && s_ready;

    always_comb begin
        row_cur     = s_first ? '0 : row_count_reg;
        col_cur     = s_first ? '0 : col_count_reg;
        col_cur_ext = {1'b0, col_cur};
        emit_now    = (row_cur >= ROW_W'(2)) && (col_cur_ext >= EW'(2))
                   && (row_cur < eff_height) && (col_cur_ext < eff_width);
        last_now    = (row_cur == eff_height - ROW_W'(1))
                   && (col_cur_ext == eff_width - EW'(1));
        center_col_ext = COL_X_W'(col_cur) - COL_X_W'(1);

        col_inc = col_cur_ext + EW'(1);
        if (col_inc >= eff_width) begin
            col_count_next = '0;
            row_inc        = {1'b0, row_cur} + (ROW_W+1)'(1);
        end else begin
            col_count_next = col_inc[COL_W-1:0];
            row_inc        = {1'b0, row_cur};
        end
        row_count_next = (row_inc >= {1'b0, eff_height}) ? '0 : row_inc[ROW_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= '0;
            col_count_reg <= '0;
        end else if (in_xfer) begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
        end
    end

    // ---------------- stage 1 ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= in_xfer;
            s1_emit_reg  <= in_xfer && emit_now;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            s1_pixel_reg <= s_pixel;
            s1_idx_reg   <= col_cur;
            s1_last_reg  <= last_now;
            s1_row_reg   <= row_cur - ROW_W'(1);
            s1_col_reg   <= center_col_ext[COL_OUT_W-1:0];
        end
    end

    assign lines_wr = '{recent: s1_pixel_reg, older: lines_rd.recent};

    cslbp_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (in_xfer),
        .rd_idx  (col_cur),
        .wr_en   (s1_valid_reg),
        .wr_idx  (s1_idx_reg),
        .wr_data (lines_wr),
        .rd_data (lines_rd)
    );

    // window slides left; new right column is older line, recent line, pixel
    always_comb begin
        window_next    = window_reg;
        window_next[0] = window_reg[1];
        window_next[1] = window_reg[2];
        window_next[2] = lines_rd.older;
        window_next[3] = window_reg[4];
        window_next[4] = window_reg[5];
        window_next[5] = lines_rd.recent;
        window_next[6] = window_reg[7];
        window_next[7] = window_reg[8];
        window_next[8] = s1_pixel_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '0;
        end else if (s1_valid_reg) begin
            window_reg <= window_next;
        end
    end

    // ---------------- stage 2 ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= s1_emit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_emit_reg) begin
            s2_row_reg  <= s1_row_reg;
            s2_col_reg  <= s1_col_reg;
            s2_last_reg <= s1_last_reg;
        end
    end

    cslbp_code_unit u_code_unit (
        .win       (window_reg),
        .threshold (diff_threshold_reg),
        .code      (s2_code)
    );

    // ---------------- output queue ----------------
    assign fifo_push = s2_valid_reg;
    assign fifo_pop  = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (fifo_push) begin
            fifo_mem[fifo_wr_ptr_reg] <= '{code: s2_code, row: s2_row_reg,
                                           col: s2_col_reg, last: s2_last_reg};
        end
    end

    always_comb begin
        fifo_cnt_next = fifo_cnt_reg;
        if (fifo_push && !fifo_pop) begin
            fifo_cnt_next = fifo_cnt_reg + (FIFO_PTR_W+1)'(1);
        end else if (!fifo_push && fifo_pop) begin
            fifo_cnt_next = fifo_cnt_reg - (FIFO_PTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fifo_wr_ptr_reg <= '0;
            fifo_rd_ptr_reg <= '0;
            fifo_cnt_reg    <= '0;
        end else begin
            if (fifo_push) begin
                fifo_wr_ptr_reg <= fifo_wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (fifo_pop) begin
                fifo_rd_ptr_reg <= fifo_rd_ptr_reg + FIFO_PTR_W'(1);
            end
            fifo_cnt_reg <= fifo_cnt_next;
        end
    end

    // credit check: every result in flight already owns a queue slot
    assign pending = fifo_cnt_reg + (FIFO_PTR_W+1)'(s1_emit_reg)
                   + (FIFO_PTR_W+1)'(s2_valid_reg);
    assign s_ready = pending < (FIFO_PTR_W+1)'(FIFO_DEPTH);

    assign head         = fifo_mem[fifo_rd_ptr_reg];
    assign m_valid      = fifo_cnt_reg != '0;
    assign m_code       = head.code;
    assign m_center_row = head.row;
    assign m_center_col = head.col;
    assign m_last       = head.last;

    // ---------------- assertions ----------------
    a_fifo_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_push |-> (fifo_cnt_reg < (FIFO_PTR_W+1)'(FIFO_DEPTH)) || fifo_pop)
        else $error("output queue overflow");

    a_credit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pending <= (FIFO_PTR_W+1)'(FIFO_DEPTH))
        else $error("results in flight exceed queue depth");

    a_first_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_first) |=> (s1_idx_reg == '0) && !s1_emit_reg)
        else $error("first pixel did not restart at column zero");

    a_push_follows_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_emit_reg) |=> !fifo_push)
        else $error("result pushed for a border pixel");

endmodule

// ===== tb/sv/center_symmetric_lbp_3x3_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for center_symmetric_lbp_3x3: raster frames of random pixels
// over a sweep of width, height and threshold settings, checked against a code predictor.
// Depends on cslbp_pkg and the block under hdl/.

module center_symmetric_lbp_3x3_test
    import cslbp_pkg::*;
;

    localparam int LINE_MAX = 1024;

    // Tracks line stores, window and position counters, and queues the codes due.
    class cslbp_code_predictor;
        logic [IMG_W_W-1:0]      width_reg;
        logic [ROW_W-1:0]        height_reg;
        logic signed [THR_W-1:0] thr_reg;
        pix_t                    row_above [LINE_MAX];
        pix_t                    row_older [LINE_MAX];
        pix_t                    win [9];
        int unsigned             row_cnt;
        int unsigned             col_cnt;
        result_t                 pending_codes [$];
        int unsigned             mismatches;

        function new();
            width_reg  = IMG_W_W'(640);
            height_reg = ROW_W'(480);
            thr_reg    = '0;
            foreach (win[i]) win[i] = '0;
            foreach (row_above[i]) begin
                row_above[i] = '0;
                row_older[i] = '0;
            end
            row_cnt     = 0;
            col_cnt     = 0;
            mismatches  = 0;
        endfunction

        function void apply_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_IMAGE_WIDTH:    width_reg  = data[IMG_W_W-1:0];
                CFG_IMAGE_HEIGHT:   height_reg = data[ROW_W-1:0];
                CFG_DIFF_THRESHOLD: thr_reg    = data[THR_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned eff_width();
            if (width_reg < MIN_DIM) return MIN_DIM;
            if (width_reg > LINE_MAX) return LINE_MAX;
            return width_reg;
        endfunction

        function int unsigned eff_height();
            if (height_reg < MIN_DIM) return MIN_DIM;
            return height_reg;
        endfunction

        function bit pair_exceeds(pix_t a, pix_t b);
            return (int'(a) - int'(b)) > int'(thr_reg);
        endfunction

        function int unsigned outstanding();
            return pending_codes.size();
        endfunction

        function void note_pixel(pix_t px, logic first_flag);
            int unsigned w;
            int unsigned h;
            int unsigned slot;
            int unsigned sum;
            pix_t        top;
            pix_t        mid;
            result_t     due;
            w = eff_width();
            h = eff_height();
            if (first_flag) begin
                row_cnt = 0;
                col_cnt = 0;
            end
            slot = col_cnt % LINE_MAX;
            top = row_older[slot];
            mid = row_above[slot];
            row_older[slot] = mid;
            row_above[slot] = px;
            win[0] = win[1]; win[1] = win[2]; win[2] = top;
            win[3] = win[4]; win[4] = win[5]; win[5] = mid;
            win[6] = win[7]; win[7] = win[8]; win[8] = px;
            if (row_cnt >= 2 && col_cnt >= 2 && row_cnt < h && col_cnt < w) begin
                due.code[0] = pair_exceeds(win[1], win[7]);
                due.code[1] = pair_exceeds(win[2], win[6]);
                due.code[2] = pair_exceeds(win[5], win[3]);
                due.code[3] = pair_exceeds(win[8], win[0]);
                sum = 0;
                foreach (win[i]) begin
                    if (i != 4) sum += win[i];
                end
                due.code[4] = win[4] > (sum >> 3);
                due.row  = ROW_W'(row_cnt - 1);
                due.col  = COL_OUT_W'(col_cnt - 1);
                due.last = (row_cnt == h - 1) && (col_cnt == w - 1);
                pending_codes.insert(pending_codes.size(), due);
            end
            col_cnt++;
            if (col_cnt >= w) begin
                col_cnt = 0;
                row_cnt++;
            end
            // a height lowered below the current row wraps at once
            if (row_cnt >= h) row_cnt = 0;
        endfunction

        function void check_code(result_t got);
            result_t want;
            if (pending_codes.size() == 0) begin
                $error("unexpected result: code %0d row %0d col %0d last %0d",
                       got.code, got.row, got.col, got.last);
                mismatches++;
                return;
            end
            want = pending_codes.pop_front();
            if (got.code !== want.code) begin
                $error("code: expected %0d, actual %0d", want.code, got.code);
                mismatches++;
            end
            if (got.row !== want.row) begin
                $error("center_row: expected %0d, actual %0d", want.row, got.row);
                mismatches++;
            end
            if (got.col !== want.col) begin
                $error("center_col: expected %0d, actual %0d", want.col, got.col);
                mismatches++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, actual %0d", want.last, got.last);
                mismatches++;
            end
        endfunction
    endclass

    localparam int ITEM_TARGET   = 850;
    localparam int PROBE_ITEMS   = 60;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 3000;
    localparam int LONG_HOLD     = 300;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata    = '0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    logic [PIX_W-1:0]      s_pixel      = '0;
    logic                  s_first      = 1'b0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    logic [CODE_W-1:0]     m_code;
    logic [ROW_W-1:0]      m_center_row;
    logic [COL_OUT_W-1:0]  m_center_col;
    logic                  m_last;

    cslbp_code_predictor codes;
    bit                  tx_idle_on   = 1'b1;
    bit                  rx_idle_on   = 1'b1;
    int unsigned         rx_hold_len  = 0;
    int unsigned         stall_cycles = 0;

    center_symmetric_lbp_3x3 #(
        .MAX_WIDTH(LINE_MAX)
    ) u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_pixel     (s_pixel),
        .s_first     (s_first),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_code      (m_code),
        .m_center_row(m_center_row),
        .m_center_col(m_center_col),
        .m_last      (m_last)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // value in the low bits, random filler above them
    function automatic logic [CFG_DATA_W-1:0] pad_random(int value, int bits);
        logic [CFG_DATA_W-1:0] word;
        word = CFG_DATA_W'($urandom);
        for (int b = 0; b < bits; b++) word[b] = value[b];
        return word;
    endfunction

    // leaves cfg_wr_en high so back-to-back writes need one assignment per edge
    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        codes.apply_setting(idx, data);
    endtask

    task automatic send_pixel(input pix_t px, input logic first_flag);
        int unsigned gap;
        gap = tx_idle_on ? $urandom_range(0, 11) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel <= px;
        s_first <= first_flag;
        do @(posedge aclk); while (s_ready !== 1'b1);
        codes.note_pixel(px, first_flag);
    endtask

    // border pixels give no result, so allow the pipeline to empty before moving on
    task automatic drain_results();
        s_valid <= 1'b0;
        while (codes.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin : code_sink
        int unsigned gap;
        result_t     got;
        wait (aresetn === 1'b1);
        forever begin
            if (rx_hold_len != 0) begin
                gap = rx_hold_len;
                rx_hold_len = 0;
            end else begin
                gap = rx_idle_on ? $urandom_range(0, 11) : 0;
            end
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            got.code = m_code;
            got.row  = m_center_row;
            got.col  = m_center_col;
            got.last = m_last;
            codes.check_code(got);
        end
    end

    initial begin : stimulus
        pix_t        frame_a [9];
        pix_t        frame_b [9];
        int unsigned phase;
        int unsigned random_items;
        int unsigned old_w;
        int unsigned wv;
        int unsigned hv;
        int unsigned frames;
        int unsigned total;
        int unsigned style;
        int unsigned px_style;
        int unsigned r;
        int          tv;
        int          v;
        pix_t        base;
        pix_t        px;
        logic        lead_first;
        logic        force_first;
        logic        first_flag;

        // bright top, dark bottom, center one above the neighbor mean
        frame_a = '{8'd255, 8'd255, 8'd255, 8'd0, 8'd128, 8'd255,
                    8'd0, 8'd0, 8'd0};
        // dark top, bright bottom: the vertical pair and one diagonal pair sit exactly on a threshold of -255
        frame_b = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                    8'd255, 8'd255, 8'd255};

        codes = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // width and height below the minimum, threshold at its top
        write_setting(CFG_IMAGE_WIDTH, 12'd0);
        write_setting(CFG_IMAGE_HEIGHT, 12'd1);
        write_setting(CFG_DIFF_THRESHOLD, 12'h0FF);
        cfg_wr_en <= 1'b0;
        foreach (frame_a[i]) send_pixel(frame_a[i], i == 0);
        drain_results();

        write_setting(CFG_UNUSED_INDEX, 12'hFFF);
        write_setting(CFG_DIFF_THRESHOLD, 12'h101);
        cfg_wr_en <= 1'b0;
        foreach (frame_b[i]) send_pixel(frame_b[i], i == 0);
        drain_results();

        phase = 0;
        random_items = 0;
        while (phase < 3 || random_items < ITEM_TARGET) begin
            old_w = codes.eff_width();
            r = $urandom_range(0, 9);
            if (r == 0) tv = $urandom_range(0, 1) ? 255 : -255;
            else if (r < 3) tv = int'($urandom_range(0, 510)) - 255;
            else tv = int'($urandom_range(0, 32)) - 16;
            case (phase)
                0: begin
                    // register maximum, clamps to the widest line; first row only
                    wv = 2047;
                    hv = 3;
                end
                1: begin
                    wv = 3;
                    hv = 4095;
                end
                2: begin
                    wv = 10;
                    hv = 6;
                end
                default: begin
                    r = $urandom_range(0, 9);
                    if (r == 0) wv = $urandom_range(0, 2);
                    else if (r == 1) wv = $urandom_range(13, 48);
                    else wv = $urandom_range(3, 12);
                    hv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2)
                                                     : $urandom_range(3, 7);
                end
            endcase
            if (phase < 3 || $urandom_range(0, 3) != 0)
                write_setting(CFG_IMAGE_WIDTH, pad_random(wv, IMG_W_W));
            if (phase < 3 || $urandom_range(0, 3) != 0)
                write_setting(CFG_IMAGE_HEIGHT, pad_random(hv, ROW_W));
            if (phase < 3 || $urandom_range(0, 3) != 0)
                write_setting(CFG_DIFF_THRESHOLD, pad_random(tv, THR_W));
            if ($urandom_range(0, 7) == 0)
                write_setting(CFG_UNUSED_INDEX, CFG_DATA_W'($urandom));
            cfg_wr_en <= 1'b0;
            // columns beyond the old width hold nothing yet, so a wider row restarts the frame
            force_first = codes.eff_width() > old_w;

            tx_idle_on = (phase >= 2) && $urandom_range(0, 3) != 0;
            rx_idle_on = (phase >= 2) && $urandom_range(0, 3) != 0;
            if (phase == 2) begin
                tx_idle_on  = 1'b0;
                rx_hold_len = LONG_HOLD;
            end else if (phase > 2 && $urandom_range(0, 9) == 0) begin
                rx_hold_len = $urandom_range(30, 200);
            end

            frames = (phase == 2) ? 2 : (phase < 2) ? 1 : $urandom_range(1, 3);
            for (int f = 0; f < frames; f++) begin
                total = codes.eff_width() * codes.eff_height();
                style = $urandom_range(0, 9);
                // the extreme shapes are only probed over their first rows
                if (phase < 2) total = PROBE_ITEMS;
                if (phase >= 3 && style < 2) total = $urandom_range(1, total - 1);
                if (phase >= 3 && random_items + total > ITEM_TARGET)
                    total = ITEM_TARGET - random_items;
                if (total == 0) break;
                // otherwise continue from wherever the counters stand
                lead_first = (f == 0 && force_first) || phase < 3 || style != 9;
                px_style = $urandom_range(0, 3);
                base = pix_t'($urandom_range(0, 255));
                for (int k = 0; k < total; k++) begin
                    case (px_style)
                        1: begin
                            v = int'(base) + int'($urandom_range(0, 8)) - 4;
                            px = pix_t'((v < 0) ? 0 : (v > 255) ? 255 : v);
                        end
                        2: px = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                        default: px = pix_t'($urandom_range(0, 255));
                    endcase
                    first_flag = (k == 0 && lead_first)
                               || (phase >= 2 && $urandom_range(0, 299) == 0);
                    send_pixel(px, first_flag);
                end
                random_items += total;
            end
            drain_results();
            phase++;
        end

        if (codes.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
